### hw/rtl/irtf_pkg.sv
`timescale 1ns / 1ps

package irtf_pkg;

  // ascii codes
  localparam logic [7:0] CH_ZERO    = 8'd48;
  localparam logic [7:0] CH_UPPER_A = 8'd65;
  localparam logic [7:0] CH_LOWER_A = 8'd97;
  localparam logic [7:0] CH_MINUS   = 8'd45;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [3:0] DIGIT_LIMIT = 4'd10;

  localparam logic [7:0] PAD_RESET = 8'd48;

  localparam int FIELD_W = 7;
  localparam int MAG_W   = 64;

  typedef enum logic [1:0] {
    BASE_BIN,
    BASE_OCT,
    BASE_DEC,
    BASE_HEX
  } base_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_NORM,
    ST_EMIT
  } state_t;

  // digit value to ascii, letters in the chosen case above nine
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base_ch;
    base_ch = upper ? CH_UPPER_A : CH_LOWER_A;
    if (d < DIGIT_LIMIT) begin
      return CH_ZERO + {4'd0, d};
    end
    return base_ch + {4'd0, d - DIGIT_LIMIT};
  endfunction

endpackage

### hw/rtl/irtf_if.sv
`timescale 1ns / 1ps

interface irtf_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [irtf_pkg::MAG_W-1:0]           magnitude;
  logic                                 is_negative;
  logic [1:0]                           base_sel;
  logic [irtf_pkg::FIELD_W-1:0]         field_width;
  logic                                 left_adjust;
  logic                                 upper_case;

  modport source (
    output valid, magnitude, is_negative, base_sel, field_width, left_adjust, upper_case,
    input  ready
  );
  modport sink (
    input  valid, magnitude, is_negative, base_sel, field_width, left_adjust, upper_case,
    output ready
  );
endinterface

interface irtf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       last;

  modport source (
    output valid, text_char, last,
    input  ready
  );
  modport sink (
    input  valid, text_char, last,
    output ready
  );
endinterface

### hw/rtl/integer_radix_text_formatter.sv
`timescale 1ns / 1ps

// integer text formatter: one request on in_chan gives one text field on out_chan,
// one ascii character per transfer there, with last set on the final character.
// cfg_we/cfg_wdata write the pad character for right-adjusted fields (reset '0').
// decimal requests run a bit-serial binary to bcd conversion, one magnitude bit
// per cycle; binary, octal and hex load their digits directly.
// leading zero digits are then shifted out one digit per cycle, and the field is
// emitted one character per cycle unless the receiver stalls, with the digits
// taken from the top of the digit shift register. per request: accept, conversion
// (decimal only), leading zero removal, layout fix, then the characters, at most
// MAX_FIELD of them.
// in_chan.ready is high only while no request is in progress.
// the last character may still sit in the output register while the next
// request is taken. a stalled receiver simply holds the output register and
// pauses emission; nothing is lost.
// reset (synchronous, active low) returns to idle, drops any pending character
// and restores the pad character.
module integer_radix_text_formatter #(
  parameter int MAX_FIELD  = 64,
  parameter int VALUE_BITS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  irtf_in_if.sink             in_chan,
  irtf_out_if.source          out_chan,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata
);

  // digit counts per radix
  localparam int NDIG_B = VALUE_BITS;
  localparam int NDIG_O = (VALUE_BITS + 2) / 3;
  localparam int NDIG_H = (VALUE_BITS + 3) / 4;
  localparam int NDIG_D = (VALUE_BITS * 30103) / 100000 + 1;

  localparam int BCD_W = 4 * NDIG_D;
  localparam int OCT_W = 3 * NDIG_O;
  localparam int HEX_W = 4 * NDIG_H;

  localparam int SW_A = (BCD_W > OCT_W) ? BCD_W : OCT_W;
  localparam int SW_B = (HEX_W > VALUE_BITS) ? HEX_W : VALUE_BITS;
  localparam int SW   = (SW_A > SW_B) ? SW_A : SW_B;

  // shifts that top-align each radix's digit field
  localparam int SH_B = SW - VALUE_BITS;
  localparam int SH_O = SW - OCT_W;
  localparam int SH_H = SW - HEX_W;
  localparam int SH_D = SW - BCD_W;

  localparam int DCW  = $clog2(VALUE_BITS + 1);
  localparam int TMAX = (VALUE_BITS + 1 > MAX_FIELD) ? VALUE_BITS + 1 : MAX_FIELD;
  localparam int TW   = $clog2(TMAX + 1);

  irtf_pkg::state_t state_r, state_nxt;

  // digit shift register, most significant digit at the top
  logic [SW-1:0]         sr_r, sr_nxt;
  logic [VALUE_BITS-1:0] bin_r, bin_nxt;
  logic [DCW-1:0]        cnt_r, cnt_nxt;
  logic [DCW-1:0]        bit_cnt_r, bit_cnt_nxt;

  // request attributes
  logic                  neg_r, neg_nxt;
  irtf_pkg::base_t       base_r, base_nxt;
  logic [TW-1:0]         width_r, width_nxt;
  logic                  left_r, left_nxt;
  logic                  upper_r, upper_nxt;

  // field layout, fixed once the digit count is known
  logic [TW-1:0]         actual_r, actual_nxt;
  logic [TW-1:0]         padn_r, padn_nxt;
  logic [TW-1:0]         len_r, len_nxt;
  logic [TW-1:0]         pos_r, pos_nxt;

  logic [7:0]            pad_r;

  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;

  logic [3:0]            top4;
  logic [3:0]            top_digit;
  logic [SW-1:0]         sr_shifted;
  logic [BCD_W-1:0]      bcd_adj;

  assign in_chan.ready      = (state_r == irtf_pkg::ST_IDLE);
  assign out_chan.valid     = out_valid_r;
  assign out_chan.text_char = out_char_r;
  assign out_chan.last      = out_last_r;

  // top digit of the shift register, narrowed to the radix
  assign top4 = sr_r[SW-1 -: 4];

  always_comb begin
    case (base_r)
      irtf_pkg::BASE_BIN: begin
        top_digit  = {3'd0, top4[3]};
        sr_shifted = sr_r << 1;
      end
      irtf_pkg::BASE_OCT: begin
        top_digit  = {1'b0, top4[3:1]};
        sr_shifted = sr_r << 3;
      end
      default: begin
        top_digit  = top4;
        sr_shifted = sr_r << 4;
      end
    endcase
  end

  // double dabble correction: every bcd digit of five or more gets three added
  always_comb begin
    logic [3:0] d;
    for (int i = 0; i < NDIG_D; i++) begin
      d = sr_r[SH_D + 4 * i +: 4];
      bcd_adj[4 * i +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
    end
  end

  always_comb begin
    logic [TW-1:0]    actual;
    logic [TW-1:0]    total;
    logic             zero_neg;
    logic             take_digit;
    logic [7:0]       ch;
    logic [BCD_W-1:0] bcd_sh;

    state_nxt     = state_r;
    sr_nxt        = sr_r;
    bin_nxt       = bin_r;
    cnt_nxt       = cnt_r;
    bit_cnt_nxt   = bit_cnt_r;
    neg_nxt       = neg_r;
    base_nxt      = base_r;
    width_nxt     = width_r;
    left_nxt      = left_r;
    upper_nxt     = upper_r;
    actual_nxt    = actual_r;
    padn_nxt      = padn_r;
    len_nxt       = len_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    actual     = TW'(cnt_r) + TW'(neg_r);
    total      = (actual > width_r) ? actual : width_r;
    zero_neg   = neg_r && (pad_r == irtf_pkg::CH_ZERO);
    take_digit = 1'b0;
    ch         = irtf_pkg::digit_char(top_digit, upper_r);
    bcd_sh     = {bcd_adj[BCD_W-2:0], bin_r[VALUE_BITS-1]};

    // receiver took the pending character
    if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      irtf_pkg::ST_IDLE: begin
        if (in_chan.valid) begin
          neg_nxt   = in_chan.is_negative;
          base_nxt  = irtf_pkg::base_t'(in_chan.base_sel);
          left_nxt  = in_chan.left_adjust;
          upper_nxt = in_chan.upper_case;
          width_nxt = (in_chan.field_width > irtf_pkg::FIELD_W'(MAX_FIELD)) ?
                      TW'(MAX_FIELD) : TW'(in_chan.field_width);
          bin_nxt   = in_chan.magnitude[VALUE_BITS-1:0];
          state_nxt = irtf_pkg::ST_NORM;
          case (irtf_pkg::base_t'(in_chan.base_sel))
            irtf_pkg::BASE_BIN: begin
              sr_nxt  = SW'(in_chan.magnitude[VALUE_BITS-1:0]) << SH_B;
              cnt_nxt = DCW'(NDIG_B);
            end
            irtf_pkg::BASE_OCT: begin
              sr_nxt  = SW'(in_chan.magnitude[VALUE_BITS-1:0]) << SH_O;
              cnt_nxt = DCW'(NDIG_O);
            end
            irtf_pkg::BASE_HEX: begin
              sr_nxt  = SW'(in_chan.magnitude[VALUE_BITS-1:0]) << SH_H;
              cnt_nxt = DCW'(NDIG_H);
            end
            default: begin
              sr_nxt      = '0;
              cnt_nxt     = DCW'(NDIG_D);
              bit_cnt_nxt = DCW'(VALUE_BITS);
              state_nxt   = irtf_pkg::ST_CONV;
            end
          endcase
        end
      end

      // one magnitude bit into the bcd field per cycle
      irtf_pkg::ST_CONV: begin
        sr_nxt      = SW'(bcd_sh) << SH_D;
        bin_nxt     = bin_r << 1;
        bit_cnt_nxt = bit_cnt_r - 1'b1;
        if (bit_cnt_r == DCW'(1)) begin
          state_nxt = irtf_pkg::ST_NORM;
        end
      end

      // drop leading zero digits, keep at least one
      irtf_pkg::ST_NORM: begin
        if ((cnt_r > DCW'(1)) && (top_digit == 4'd0)) begin
          sr_nxt  = sr_shifted;
          cnt_nxt = cnt_r - 1'b1;
        end else begin
          actual_nxt = actual;
          padn_nxt   = total - actual;
          len_nxt    = (total > TW'(MAX_FIELD)) ? TW'(MAX_FIELD) : total;
          pos_nxt    = '0;
          state_nxt  = irtf_pkg::ST_EMIT;
        end
      end

      irtf_pkg::ST_EMIT: begin
        if (!out_valid_r || out_chan.ready) begin
          if (left_r) begin
            if (neg_r && (pos_r == '0)) begin
              ch = irtf_pkg::CH_MINUS;
            end else if (pos_r < actual_r) begin
              take_digit = 1'b1;
            end else begin
              ch = irtf_pkg::CH_SPACE;
            end
          end else if (zero_neg) begin
            // sign goes ahead of the zero padding
            if (pos_r == '0) begin
              ch = irtf_pkg::CH_MINUS;
            end else if (pos_r <= padn_r) begin
              ch = irtf_pkg::CH_ZERO;
            end else begin
              take_digit = 1'b1;
            end
          end else begin
            if (pos_r < padn_r) begin
              ch = pad_r;
            end else if (neg_r && (pos_r == padn_r)) begin
              ch = irtf_pkg::CH_MINUS;
            end else begin
              take_digit = 1'b1;
            end
          end

          if (take_digit) begin
            sr_nxt = sr_shifted;
          end
          out_valid_nxt = 1'b1;
          out_char_nxt  = ch;
          out_last_nxt  = (pos_r == len_r - 1'b1);
          pos_nxt       = pos_r + 1'b1;
          if (pos_r == len_r - 1'b1) begin
            state_nxt = irtf_pkg::ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = irtf_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= irtf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      pad_r       <= irtf_pkg::PAD_RESET;
      cnt_r       <= '0;
      bit_cnt_r   <= '0;
      pos_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      pos_r       <= pos_nxt;
      if (cfg_we) begin
        pad_r <= cfg_wdata;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    sr_r       <= sr_nxt;
    bin_r      <= bin_nxt;
    neg_r      <= neg_nxt;
    base_r     <= base_nxt;
    width_r    <= width_nxt;
    left_r     <= left_nxt;
    upper_r    <= upper_nxt;
    actual_r   <= actual_nxt;
    padn_r     <= padn_nxt;
    len_r      <= len_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule
